// ----- hw/rtl/tmtc_pkg.sv -----
// Package for the tempo map tick/time converter.
// Holds shared types and fixed constants. No dependencies.
`timescale 1ns / 1ps
package tmtc_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_T2U    = 2'd1;
  localparam logic [1:0] OP_U2T    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic REG_TPB = 1'b0;
  localparam logic REG_CNT = 1'b1;

  // Microseconds per minute times 1000
  localparam logic [35:0] US_MILLI_PER_MIN = 36'd60000000000;
  localparam logic [43:0] TIME_MAX = 44'hFFFFFFFFFFF;
  localparam logic [30:0] TICK_MAX = 31'h7FFFFFFF;

  localparam logic [15:0] TPB_RESET = 16'd480;
  localparam logic [6:0]  CNT_RESET = 7'd1;

  // One tempo table entry
  typedef struct packed {
    logic [30:0] start;
    logic [19:0] rate;
  } tmtc_entry_t;

  // Request to the multiply-divide unit: floor(a * b / d)
  typedef struct packed {
    logic        start;
    logic [43:0] a;
    logic [35:0] b;
    logic [35:0] d;
  } md_req_t;

endpackage

// ----- hw/rtl/tmtc_table.sv -----
// Tempo table memory: one write port, one registered read port.
// Depends on tmtc_pkg for the entry type.
`timescale 1ns / 1ps
module tmtc_table
  import tmtc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tmtc_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output tmtc_entry_t   rdata
);

  tmtc_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tmtc_muldiv.sv -----
// Multiply-divide unit: floor(a * b / d), a 44x36 multiply then
// an 80-step restoring divider. Depends on tmtc_pkg for the request type.
`timescale 1ns / 1ps
module tmtc_muldiv
  import tmtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  md_req_t     req,
  output logic        done,
  output logic [79:0] q
);

  localparam logic [2:0] MD_IDLE = 3'd0;
  localparam logic [2:0] MD_LO   = 3'd1;
  localparam logic [2:0] MD_HI   = 3'd2;
  localparam logic [2:0] MD_SUM  = 3'd3;
  localparam logic [2:0] MD_DIV  = 3'd4;

  localparam logic [6:0] LAST_STEP = 7'd79;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [43:0] a_r;
  logic [35:0] b_r, d_r;
  logic [57:0] plo_r, phi_r;
  logic [79:0] num_r;
  logic [35:0] rem_r;
  logic [36:0] shifted;
  logic        fits;

  // one restoring division step
  always_comb begin
    shifted = {rem_r, num_r[79]};
    fits    = shifted >= {1'b0, d_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_LO;
      MD_LO:   state_nxt = MD_HI;
      MD_HI:   state_nxt = MD_SUM;
      MD_SUM: begin
        cnt_nxt   = '0;
        state_nxt = MD_DIV;
      end
      MD_DIV: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == LAST_STEP) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath: operand latch, partial products, divider
  always_ff @(posedge clk) begin
    if (state_r == MD_IDLE && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      d_r <= req.d;
    end
    if (state_r == MD_LO) plo_r <= 58'(a_r[21:0]) * 58'(b_r);
    if (state_r == MD_HI) phi_r <= 58'(a_r[43:22]) * 58'(b_r);
    if (state_r == MD_SUM) begin
      num_r <= {phi_r, 22'b0} + {22'b0, plo_r};
      rem_r <= '0;
    end
    if (state_r == MD_DIV) begin
      rem_r <= fits ? 36'(shifted - {1'b0, d_r}) : shifted[35:0];
      num_r <= {num_r[78:0], fits};
    end
  end

  assign done = done_r;
  assign q    = num_r;

endmodule

// ----- hw/rtl/tempo_map_tick_time_convert.sv -----
// Top level of the tempo map tick/time converter.
// Uses tmtc_pkg, tmtc_table (tempo memory) and tmtc_muldiv (conversions).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: a table write (op 0),
//   a tick-to-time query (op 1) or a time-to-tick query (op 2). Every item
//   gives exactly one result item on the out_ channel, in order.
//   The APB-style port holds the tick resolution in ticks per beat
//   (address 0) and entry_count (address 4); write them only while idle.
//   One item is worked on at a time; in_ready is high only when idle.
//   A write item or an unused op skips the walk and goes straight to S_DONE.
//   A query reads the table one entry at a time and converts each walked
//   segment and the remainder on the shared multiply-divide unit, whose
//   80-step divider sets the time of each conversion. Zero ticks or zero
//   tempo skip the divider, but only in a tick-to-time conversion.
//   The result waits in an output register; a finished item whose result
//   finds the register still full holds until out_ready frees it, and the
//   next item may be accepted while the result waits.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the tick
//   resolution to 480 and entry_count to 1; table contents are undefined.
//
module tempo_map_tick_time_convert
  import tmtc_pkg::*;
#(
  parameter int MAX_TEMPOS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_entry_index,
  input  logic [30:0] in_entry_start_tick,
  input  logic [19:0] in_entry_bpm_milli,
  input  logic [30:0] in_query_tick,
  input  logic [43:0] in_query_time_us,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [43:0] out_time_us,
  output logic [30:0] out_tick_result,
  output logic        out_saturated,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_TEMPOS > 1) ? $clog2(MAX_TEMPOS) : 1;
  localparam int CW = $clog2(MAX_TEMPOS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD0    = 4'd1;
  localparam logic [3:0] S_RDW    = 4'd2;
  localparam logic [3:0] S_SEG    = 4'd3;
  localparam logic [3:0] S_CSTART = 4'd4;
  localparam logic [3:0] S_CWAIT  = 4'd5;
  localparam logic [3:0] S_POST   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // configuration registers
  logic [15:0] tpb_r;
  logic [6:0]  cnt_r;
  logic        cfg_wr;
  logic [15:0] tpb_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign tpb_eff = (tpb_r == 16'd0) ? 16'd1 : tpb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r <= TPB_RESET;
      cnt_r <= CNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TPB: tpb_r <= pwdata[15:0];
        REG_CNT: cnt_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TPB: prdata = {16'b0, tpb_r};
      REG_CNT: prdata = {25'b0, cnt_r};
      default: prdata = '0;
    endcase
  end

  // registers of the walk
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [30:0]   qtick_r, qtick_nxt;
  logic [43:0]   qus_r, qus_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [30:0]   cur_start_r, cur_start_nxt;
  logic [19:0]   cur_rate_r, cur_rate_nxt;
  logic [30:0]   nxt_start_r, nxt_start_nxt;
  logic [19:0]   nxt_rate_r, nxt_rate_nxt;
  logic [30:0]   seg_r, seg_nxt;
  logic [43:0]   acc_r, acc_nxt;
  logic [44:0]   total_r, total_nxt;
  logic          sat_r, sat_nxt;
  logic [43:0]   conv_t_r, conv_t_nxt;
  logic          conv_u2t_r, conv_u2t_nxt;
  logic          fin_r, fin_nxt;
  logic [45:0]   conv_res_r, conv_res_nxt;
  logic          conv_sat_r, conv_sat_nxt;
  logic [35:0]   rt_r;
  logic          out_valid_r, out_valid_nxt;
  logic [43:0]   out_time_r, out_time_nxt;
  logic [30:0]   out_tick_r, out_tick_nxt;
  logic          out_sat_r, out_sat_nxt;

  logic          in_acc;
  logic [CW-1:0] i_p1, i_p2, n_in;
  logic [AW-1:0] raddr;
  tmtc_entry_t   rdata, wdata;
  logic          mem_we;
  md_req_t       md_req;
  logic          md_done;
  logic [79:0]   md_q;
  logic [45:0]   sum_res;
  logic [44:0]   acc_dur;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign i_p1     = CW'(i_r) + CW'(1);
  assign i_p2     = i_p1 + CW'(1);

  // entries in use: zero means one, clamp at the table depth
  always_comb begin
    if (cnt_r == 7'd0) n_in = CW'(1);
    else if (32'(cnt_r) > MAX_TEMPOS) n_in = CW'(MAX_TEMPOS);
    else n_in = CW'(cnt_r);
  end

  // table write happens at acceptance; no query runs then
  assign mem_we      = in_acc && (in_op == OP_WRITE) && (32'(in_entry_index) < MAX_TEMPOS);
  assign wdata.start = in_entry_start_tick;
  assign wdata.rate  = in_entry_bpm_milli;
  assign raddr       = (state_r == S_IDLE) ? '0 : i_p1[AW-1:0];

  tmtc_table #(
    .DEPTH(MAX_TEMPOS),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(in_entry_index)),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // divisor or multiplier for the tempo in force
  always_ff @(posedge clk) begin
    rt_r <= 36'(cur_rate_r) * 36'(tpb_eff);
  end

  assign md_req.start = (state_r == S_CSTART) &&
                        (conv_u2t_r || (conv_t_r != '0 && cur_rate_r != '0));
  assign md_req.a     = conv_t_r;
  assign md_req.b     = conv_u2t_r ? rt_r : US_MILLI_PER_MIN;
  assign md_req.d     = conv_u2t_r ? US_MILLI_PER_MIN : rt_r;

  tmtc_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (md_req),
    .done (md_done),
    .q    (md_q)
  );

  assign sum_res = {1'b0, total_r} + conv_res_r;
  assign acc_dur = {1'b0, acc_r} + conv_res_r[44:0];

  // walk sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    qtick_nxt     = qtick_r;
    qus_nxt       = qus_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    cur_start_nxt = cur_start_r;
    cur_rate_nxt  = cur_rate_r;
    nxt_start_nxt = nxt_start_r;
    nxt_rate_nxt  = nxt_rate_r;
    seg_nxt       = seg_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    sat_nxt       = sat_r;
    conv_t_nxt    = conv_t_r;
    conv_u2t_nxt  = conv_u2t_r;
    fin_nxt       = fin_r;
    conv_res_nxt  = conv_res_r;
    conv_sat_nxt  = conv_sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_time_nxt  = out_time_r;
    out_tick_nxt  = out_tick_r;
    out_sat_nxt   = out_sat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          qtick_nxt = in_query_tick;
          qus_nxt   = in_query_time_us;
          n_nxt     = n_in;
          i_nxt     = '0;
          acc_nxt   = '0;
          total_nxt = '0;
          sat_nxt   = 1'b0;
          fin_nxt   = 1'b0;
          if (in_op == OP_T2U || in_op == OP_U2T) state_nxt = S_LD0;
          else state_nxt = S_DONE;
        end
      end
      S_LD0: begin
        cur_start_nxt = rdata.start;
        cur_rate_nxt  = rdata.rate;
        state_nxt     = (n_r > CW'(1)) ? S_SEG : S_FIN;
      end
      S_RDW: state_nxt = S_SEG;
      S_SEG: begin
        nxt_start_nxt = rdata.start;
        nxt_rate_nxt  = rdata.rate;
        seg_nxt       = (rdata.start >= cur_start_r) ? rdata.start - cur_start_r : '0;
        conv_t_nxt    = 44'(seg_nxt);
        conv_u2t_nxt  = 1'b0;
        fin_nxt       = 1'b0;
        if (op_r == OP_T2U && ({1'b0, acc_r} + 45'(seg_nxt)) >= 45'(qtick_r)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CSTART;
        end
      end
      S_FIN: begin
        fin_nxt = 1'b1;
        if (op_r == OP_T2U) begin
          conv_t_nxt   = (qtick_r >= cur_start_r) ? 44'(qtick_r - cur_start_r) : '0;
          conv_u2t_nxt = 1'b0;
        end else begin
          conv_t_nxt   = qus_r - acc_r;
          conv_u2t_nxt = 1'b1;
        end
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        // zero ticks take no time; zero tempo takes forever
        if (!conv_u2t_r && conv_t_r == '0) begin
          conv_res_nxt = '0;
          conv_sat_nxt = 1'b0;
          state_nxt    = S_POST;
        end else if (!conv_u2t_r && cur_rate_r == '0) begin
          conv_res_nxt = 46'(TIME_MAX);
          conv_sat_nxt = 1'b1;
          state_nxt    = S_POST;
        end else begin
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (md_done) begin
          if (conv_u2t_r) begin
            conv_res_nxt = md_q[45:0];
            conv_sat_nxt = 1'b0;
          end else if (md_q[79:44] != '0) begin
            conv_res_nxt = 46'(TIME_MAX);
            conv_sat_nxt = 1'b1;
          end else begin
            conv_res_nxt = {2'b0, md_q[43:0]};
            conv_sat_nxt = 1'b0;
          end
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (op_r == OP_T2U) begin
          // saturating time sum
          if (sum_res > 46'(TIME_MAX)) begin
            total_nxt = 45'(TIME_MAX);
            sat_nxt   = 1'b1;
          end else begin
            total_nxt = sum_res[44:0];
          end
          if (conv_sat_r) sat_nxt = 1'b1;
          if (!fin_r) acc_nxt = acc_r + 44'(seg_r);
        end else if (fin_r) begin
          // saturating tick sum
          if (sum_res > 46'(TICK_MAX)) begin
            total_nxt = 45'(TICK_MAX);
            sat_nxt   = 1'b1;
          end else begin
            total_nxt = sum_res[44:0];
          end
        end else if (acc_dur < {1'b0, qus_r}) begin
          total_nxt = total_r + 45'(seg_r);
          acc_nxt   = acc_dur[43:0];
        end
        if (fin_r) begin
          state_nxt = S_DONE;
        end else if (op_r == OP_U2T && acc_dur >= {1'b0, qus_r}) begin
          // remaining time falls inside this segment
          state_nxt = S_FIN;
        end else begin
          // step to the next segment
          i_nxt         = i_r + AW'(1);
          cur_start_nxt = nxt_start_r;
          cur_rate_nxt  = nxt_rate_r;
          state_nxt     = (i_p2 < n_r) ? S_RDW : S_FIN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = (op_r == OP_T2U) ? total_r[43:0] : '0;
          out_tick_nxt  = (op_r == OP_U2T) ? total_r[30:0] : '0;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    qtick_r     <= qtick_nxt;
    qus_r       <= qus_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    cur_start_r <= cur_start_nxt;
    cur_rate_r  <= cur_rate_nxt;
    nxt_start_r <= nxt_start_nxt;
    nxt_rate_r  <= nxt_rate_nxt;
    seg_r       <= seg_nxt;
    acc_r       <= acc_nxt;
    total_r     <= total_nxt;
    sat_r       <= sat_nxt;
    conv_t_r    <= conv_t_nxt;
    conv_u2t_r  <= conv_u2t_nxt;
    fin_r       <= fin_nxt;
    conv_res_r  <= conv_res_nxt;
    conv_sat_r  <= conv_sat_nxt;
    out_time_r  <= out_time_nxt;
    out_tick_r  <= out_tick_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_time_us     = out_time_r;
  assign out_tick_result = out_tick_r;
  assign out_saturated   = out_sat_r;

  // checks
  a_md_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_CWAIT)
    else $error("divider finished outside of a wait");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEG |-> i_p1 < n_r)
    else $error("segment read past the entries in use");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_time_us == TIME_MAX || out_tick_result == TICK_MAX))
    else $error("saturated result not clamped");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in progress");

endmodule

// ----- bench/tmtc_checker.sv -----
// Result checker for the tempo map tick/time converter bench.
// Watches item, result and config traffic; depends on tmtc_pkg only.
`timescale 1ns / 1ps
module tmtc_checker
  import tmtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_entry_index,
  input  logic [30:0] in_entry_start_tick,
  input  logic [19:0] in_entry_bpm_milli,
  input  logic [30:0] in_query_tick,
  input  logic [43:0] in_query_time_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [43:0] out_time_us,
  input  logic [30:0] out_tick_result,
  input  logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [43:0] time_us;
    logic [30:0] tick;
    logic        sat;
  } conv_result_t;

  localparam int MAP_DEPTH = 64;
  localparam logic [127:0] K_US = 128'(US_MILLI_PER_MIN);

  // Shadow of the tempo map and config registers
  logic [30:0]  tempo_start [MAP_DEPTH];
  logic [19:0]  tempo_rate  [MAP_DEPTH];
  logic [15:0]  tpb;
  logic [6:0]   cnt;
  conv_result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    tpb        = TPB_RESET;
    cnt        = CNT_RESET;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      tempo_start[i] = '0;
      tempo_rate[i]  = '0;
    end
  end

  function automatic logic [63:0] tpb_eff();
    return (tpb == 0) ? 64'd1 : 64'(tpb);
  endfunction

  function automatic int map_len();
    if (cnt == 0) return 1;
    if (cnt > MAP_DEPTH) return MAP_DEPTH;
    return int'(cnt);
  endfunction

  function automatic logic [63:0] seg_ticks(int i);
    if (tempo_start[i + 1] >= tempo_start[i])
      return 64'(tempo_start[i + 1] - tempo_start[i]);
    return 64'd0;
  endfunction

  // Ticks at a tempo to microseconds, clamped to the time range
  function automatic logic [63:0] ticks_to_time(logic [63:0] t, logic [19:0] r,
                                                output bit s);
    logic [127:0] q;
    s = 0;
    if (t == 0) return 64'd0;
    if (r == 0) begin
      s = 1;
      return 64'(TIME_MAX);
    end
    q = (128'(t) * K_US) / (128'(r) * 128'(tpb_eff()));
    if (q > 128'(TIME_MAX)) begin
      s = 1;
      return 64'(TIME_MAX);
    end
    return q[63:0];
  endfunction

  // Microseconds at a tempo to ticks, unclamped
  function automatic logic [127:0] time_to_ticks(logic [63:0] u, logic [19:0] r);
    return (128'(u) * 128'(r) * 128'(tpb_eff())) / K_US;
  endfunction

  function automatic conv_result_t convert(logic [1:0] op, logic [30:0] qt,
                                           logic [43:0] qu);
    conv_result_t res;
    logic [63:0]  acc, total, seg, dur, rem, part;
    logic [127:0] wide;
    bit           sat, s;
    int           n, last;
    res  = '0;
    sat  = 0;
    n    = map_len();
    last = 0;
    acc  = 0;
    total = 0;
    if (op == OP_T2U) begin
      for (int i = 0; i + 1 < n; i++) begin
        seg  = seg_ticks(i);
        last = i;
        if (acc + seg >= 64'(qt)) break;
        acc += seg;
        part = ticks_to_time(seg, tempo_rate[i], s);
        sat |= s;
        if (total + part > 64'(TIME_MAX)) begin
          sat = 1;
          total = 64'(TIME_MAX);
        end else total += part;
        last = i + 1;
      end
      rem  = (qt >= tempo_start[last]) ? 64'(qt - tempo_start[last]) : 64'd0;
      part = ticks_to_time(rem, tempo_rate[last], s);
      sat |= s;
      if (total + part > 64'(TIME_MAX)) begin
        sat = 1;
        total = 64'(TIME_MAX);
      end else total += part;
      res.time_us = total[43:0];
      res.sat     = sat;
    end else if (op == OP_U2T) begin
      for (int i = 0; i + 1 < n; i++) begin
        seg  = seg_ticks(i);
        dur  = ticks_to_time(seg, tempo_rate[i], s);
        last = i;
        if (acc + dur >= 64'(qu)) break;
        total += seg;
        acc   += dur;
        last = i + 1;
      end
      wide = 128'(total) + time_to_ticks(64'(qu) - acc, tempo_rate[last]);
      if (wide > 128'(TICK_MAX)) begin
        sat  = 1;
        wide = 128'(TICK_MAX);
      end
      res.tick = wide[30:0];
      res.sat  = sat;
    end
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Track items, results and register writes at each edge
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n) begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_CNT) cnt <= pwdata[6:0];
        else tpb <= pwdata[15:0];
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(convert(in_op, in_query_tick, in_query_time_us));
        if (in_op == OP_WRITE) begin
          tempo_start[in_entry_index] = in_entry_start_tick;
          tempo_rate[in_entry_index]  = in_entry_bpm_milli;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) report("unexpected result", 64'd0, 64'd0);
        else begin
          want = expected_results.pop_front();
          if (out_time_us !== want.time_us)
            report("time_us", 64'(out_time_us), 64'(want.time_us));
          if (out_tick_result !== want.tick)
            report("tick_result", 64'(out_tick_result), 64'(want.tick));
          if (out_saturated !== want.sat)
            report("saturated", 64'(out_saturated), 64'(want.sat));
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- bench/tempo_map_tick_time_convert_tb.sv -----
// Testbench top for the tempo map tick/time converter.
// Drives items and register writes; uses tmtc_pkg, tmtc_checker and the DUT.
`timescale 1ns / 1ps
module tempo_map_tick_time_convert_tb
  import tmtc_pkg::*;
();

  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 40000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_op = OP_WRITE;
  logic [5:0]  in_entry_index = '0;
  logic [30:0] in_entry_start_tick = '0;
  logic [19:0] in_entry_bpm_milli = '0;
  logic [30:0] in_query_tick = '0;
  logic [43:0] in_query_time_us = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [43:0] out_time_us;
  logic [30:0] out_tick_result;
  logic        out_saturated;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;
  logic        in_fire = 0;
  logic [6:0]  cur_cnt = CNT_RESET;
  logic [30:0] map_start [64];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  tempo_map_tick_time_convert DUT (.*);

  tmtc_checker u_checker (.*);

  // Accept flag seen by the driver at the following falling edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [5:0] idx, logic [30:0] st, logic [19:0] bpm,
                      logic [30:0] qt, logic [43:0] qu);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_op = op;
    in_entry_index = idx;
    in_entry_start_tick = st;
    in_entry_bpm_milli = bpm;
    in_query_tick = qt;
    in_query_time_us = qu;
    in_valid = 1;
    do @(negedge clk); while (!in_fire);
    items_sent++;
  endtask

  task automatic write_entry(logic [5:0] idx, logic [30:0] st, logic [19:0] bpm);
    send(OP_WRITE, idx, st, bpm, 31'($urandom), {12'($urandom), 32'($urandom)});
  endtask

  task automatic query(logic [1:0] op, logic [30:0] qt, logic [43:0] qu);
    send(op, 6'($urandom), 31'($urandom), 20'($urandom), qt, qu);
  endtask

  // Let every result drain before the registers change
  task automatic drain();
    in_valid = 0;
    do @(negedge clk); while (pending != 0 || out_valid);
    repeat (5) @(negedge clk);
  endtask

  task automatic reg_write(logic regsel, logic [31:0] data);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {regsel, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  function automatic logic [19:0] pick_rate();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 20'd0;
    if (r < 6) return 20'hFFFFF;
    if (r < 10) return 20'd1000;
    if (r < 13) return 20'd999999;
    return 20'($urandom_range(1000, 999999));
  endfunction

  // Rewrite entries 0..n-1 as a rising map, now and then out of order
  task automatic build_map(int n);
    logic [31:0] pos;
    int r;
    pos = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i == 0) pos = (r < 8) ? $urandom_range(1, 5000) : 0;
      else if (r < 6) pos = (pos > 1000) ? pos - $urandom_range(1, 1000) : pos;
      else if (r < 55) pos += $urandom_range(1, 2000);
      else if (r < 88) pos += $urandom_range(1, 1 << 20);
      else pos += $urandom_range(1, 1 << 27);
      if (pos > 32'(TICK_MAX)) pos = 32'(TICK_MAX);
      map_start[i] = pos[30:0];
      write_entry(6'(i), pos[30:0], pick_rate());
    end
  endtask

  task automatic random_item(int n);
    longint t;
    int r;
    r = $urandom_range(99);
    if (r < 5) send(OP_UNUSED, 6'($urandom), 31'($urandom), 20'($urandom), 31'($urandom),
                    {12'($urandom), 32'($urandom)});
    else if (r < 12) write_entry(6'($urandom_range(n, 63)), 31'($urandom), pick_rate());
    else if (r < 56) begin
      r = $urandom_range(99);
      if (r < 50) begin
        t = longint'(map_start[$urandom_range(n - 1)]) + $urandom_range(0, 600) - 300;
        if (t < 0) t = 0;
        if (t > longint'(TICK_MAX)) t = longint'(TICK_MAX);
      end else if (r < 80) t = $urandom_range(0, 1 << 24);
      else if (r < 90) t = longint'(TICK_MAX) - $urandom_range(0, 3);
      else t = longint'(31'($urandom));
      query(OP_T2U, 31'(t), '0);
    end else begin
      r = $urandom_range(99);
      if (r < 45) query(OP_U2T, '0, 44'($urandom_range(0, 1 << 30)));
      else if (r < 85) query(OP_U2T, '0, {12'($urandom), 32'($urandom)});
      else if (r < 93) query(OP_U2T, '0, TIME_MAX - 44'($urandom_range(0, 3)));
      else query(OP_U2T, '0, 44'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int n;
    int ph;
    int quota;
    logic [15:0] tpb_v;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed: defaults, field extremes, unused op, zero tempo, late first entry
    write_entry(6'd0, 31'd0, 20'd120000);
    query(OP_T2U, 31'd0, '0);
    query(OP_T2U, TICK_MAX, '0);
    query(OP_T2U, 31'd480, '0);
    query(OP_U2T, '0, 44'd0);
    query(OP_U2T, '0, TIME_MAX);
    query(OP_U2T, '0, 44'd500000);
    send(OP_UNUSED, 6'h3F, TICK_MAX, 20'hFFFFF, TICK_MAX, TIME_MAX);
    write_entry(6'd63, TICK_MAX, 20'hFFFFF);
    write_entry(6'd0, 31'd0, 20'd0);
    query(OP_T2U, 31'd5, '0);
    query(OP_T2U, 31'd0, '0);
    query(OP_U2T, '0, 44'd1000);
    write_entry(6'd0, 31'd100, 20'd1000);
    query(OP_T2U, 31'd50, '0);
    query(OP_T2U, TICK_MAX, '0);
    query(OP_U2T, '0, TIME_MAX);
    write_entry(6'd0, 31'd0, 20'd999999);
    query(OP_U2T, '0, TIME_MAX);
    query(OP_T2U, TICK_MAX, '0);

    // Random phases over register settings and idle patterns
    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case ((ph + ph / 8) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      tpb_v = 16'($urandom_range(1, 65535));
      case (ph % 8)
        0: begin tpb_v = TPB_RESET; cur_cnt = 7'd1; end
        1: begin tpb_v = 16'd1; cur_cnt = 7'd3; end
        2: begin tpb_v = 16'hFFFF; cur_cnt = 7'd4; end
        3: begin tpb_v = 16'd0; cur_cnt = 7'd0; end
        4: cur_cnt = 7'($urandom_range(2, 6));
        5: cur_cnt = (ph % 16 == 5) ? 7'd64 : 7'd127;
        6: cur_cnt = 7'd2;
        default: cur_cnt = 7'($urandom_range(1, 8));
      endcase
      if (ph % 3 == 0) tpb_v = 16'($urandom_range(1, 8));
      reg_write(REG_TPB, {16'd0, tpb_v});
      reg_write(REG_CNT, {25'd0, cur_cnt});
      n = (cur_cnt == 0) ? 1 : (cur_cnt > 64) ? 64 : int'(cur_cnt);
      build_map(n);
      quota = (n > 8) ? 14 : 70;
      for (int k = 0; k < quota && items_sent < ITEM_TARGET; k++) random_item(n);
      ph++;
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
